// File: rtl/euler_angles_to_rotation_matrix_top_assert.svh
// Assertion macros shared by the checker files
`ifndef EULER_ANGLES_TO_ROTATION_MATRIX_TOP_ASSERT_SVH
`define EULER_ANGLES_TO_ROTATION_MATRIX_TOP_ASSERT_SVH
// a implies b in the same cycle
`define EAR_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("%s failed", "lbl");
// a implies b after a fixed number of cycles
`define EAR_ASSERT_DLY(lbl, a, n, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> ##n (b)) \
    else $error("%s failed", "lbl");
`endif

// File: rtl/ear_pkg.sv
// ---------------------------------------------------------------------------
// ear_pkg
// Item types and constants for the rotation matrix block.
// ---------------------------------------------------------------------------
package ear_pkg;
  typedef struct packed {
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic signed [15:0] roll_angle;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m10;
    logic signed [15:0] m20;
    logic signed [15:0] m01;
    logic signed [15:0] m11;
    logic signed [15:0] m21;
    logic signed [15:0] m02;
    logic signed [15:0] m12;
    logic signed [15:0] m22;
  } out_item_t;

  // odd Taylor coefficients of sin(pi/2 x), Q30, highest power first
  localparam int NCOEF = 6;
  localparam logic signed [31:0] COEF [NCOEF] = '{
    -32'sd3864, 32'sd172271, -32'sd5026994, 32'sd85569306,
    -32'sd693598669, 32'sd1686629713
  };

  // sine pipeline depth: phase, x2, five Horner steps, final product, round
  localparam int SIN_LAT = 9;
  // matrix pipeline depth
  localparam int MAT_LAT = 4;
endpackage

// File: rtl/euler_angles_to_rotation_matrix_top.sv
// ---------------------------------------------------------------------------
// euler_angles_to_rotation_matrix_top
// Yaw-pitch-roll binary angles to a 3x3 rotation matrix in Q1.15.
// ---------------------------------------------------------------------------
// Usage:
//   Drive in_item with three binary angles and raise start; the item is
//   taken at any edge where start is high and busy is low. busy is high
//   only while reset is held, so one item is taken every cycle.
//   Six sine lanes (sine and cosine of each angle) run side by side, each a
//   nine-stage pipeline of fold, Q30 multiplies and round; a four-stage merge
//   forms the nine entries. out_valid pulses for one cycle with out_item;
//   the receiver cannot stall and must take it then. Throughput is one
//   item per cycle.
//   Synchronous active-low reset clears the valid pipeline; items in flight
//   are dropped.
// ---------------------------------------------------------------------------
module euler_angles_to_rotation_matrix_top #(
  parameter int ANGLE_BITS = 16,
  parameter int COEF_BITS  = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ear_pkg::in_item_t   in_item,
  output logic                out_valid,
  output ear_pkg::out_item_t  out_item
);
  localparam int LAT = ear_pkg::SIN_LAT + ear_pkg::MAT_LAT;
  localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

  logic [ANGLE_BITS-1:0] ph [3];
  logic signed [COEF_BITS-1:0] sn [3];
  logic signed [COEF_BITS-1:0] cs [3];
  logic [LAT-1:0] vld_r;

  // sign-extend then wrap each angle to the phase width
  assign ph[0] = ANGLE_BITS'(32'(in_item.pitch_angle));
  assign ph[1] = ANGLE_BITS'(32'(in_item.yaw_angle));
  assign ph[2] = ANGLE_BITS'(32'(in_item.roll_angle));

  for (genvar i = 0; i < 3; i++) begin : g_lane
    ear_sine_lane #(.ANGLE_BITS(ANGLE_BITS), .COEF_BITS(COEF_BITS)) u_sin (
      .clk(clk), .phase(ph[i]), .sine(sn[i]));
    ear_sine_lane #(.ANGLE_BITS(ANGLE_BITS), .COEF_BITS(COEF_BITS)) u_cos (
      .clk(clk), .phase(ph[i] + QUARTER), .sine(cs[i]));
  end

  ear_matrix #(.COEF_BITS(COEF_BITS)) u_mat (
    .clk(clk), .sp(sn[0]), .cp(cs[0]), .sy(sn[1]), .cy(cs[1]),
    .sr(sn[2]), .cr(cs[2]), .mat(out_item));

  // advance the valid line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], start & ~busy};
    end
  end

  assign busy      = ~rst_n;
  assign out_valid = vld_r[LAT-1];
endmodule

// File: rtl/ear_sine_lane.sv
// ---------------------------------------------------------------------------
// ear_sine_lane
// Pipelined sine of a binary angle: quadrant fold, Horner polynomial in Q30.
// ---------------------------------------------------------------------------
module ear_sine_lane #(
  parameter int ANGLE_BITS = 16,
  parameter int COEF_BITS  = 16
) (
  input  logic                        clk,
  input  logic [ANGLE_BITS-1:0]       phase,
  output logic signed [COEF_BITS-1:0] sine
);
  localparam int RBITS = ANGLE_BITS - 2;
  localparam int FRAC  = COEF_BITS - 2;
  localparam int NSTEP = ear_pkg::NCOEF - 1;

  // round half up by a fixed shift, arithmetic (floor) shift is exact here
  function automatic logic signed [63:0] rnd(input logic signed [63:0] v, input int sh);
    logic signed [63:0] t;
    t = v + (64'sd1 <<< (sh - 1));
    return t >>> sh;
  endfunction

  logic signed [31:0] x_r;
  logic               neg_r [ear_pkg::SIN_LAT-1];
  logic signed [31:0] xp_r  [NSTEP+1];
  logic signed [31:0] x2_r;
  logic signed [31:0] acc_r [NSTEP+1];
  logic signed [31:0] fin_r;
  logic signed [COEF_BITS-1:0] sine_r;
  logic [31:0] r_al;
  logic signed [63:0] fin_round;

  // fold the quadrant into x in Q30
  assign r_al = 32'(phase[RBITS-1:0]) << (30 - RBITS);
  always_ff @(posedge clk) begin
    x_r      <= phase[RBITS] ? (32'sd1 <<< 30) - $signed(r_al) : $signed(r_al);
    neg_r[0] <= phase[ANGLE_BITS-1];
  end

  // square x
  always_ff @(posedge clk) begin
    x2_r     <= 32'(rnd(64'(x_r) * 64'(x_r), 30));
    xp_r[0]  <= x_r;
    acc_r[0] <= ear_pkg::COEF[0];
    neg_r[1] <= neg_r[0];
  end

  // Horner steps, one per stage
  for (genvar i = 1; i <= NSTEP; i++) begin : g_horner
    logic signed [31:0] x2d_r;
    if (i == 1) begin : g_first
      assign x2d_r = x2_r;
    end else begin : g_rest
      assign x2d_r = g_horner[i-1].x2q_r;
    end
    logic signed [31:0] x2q_r;
    always_ff @(posedge clk) begin
      acc_r[i]   <= ear_pkg::COEF[i] + 32'(rnd(64'(acc_r[i-1]) * 64'(x2d_r), 30));
      x2q_r      <= x2d_r;
      xp_r[i]    <= xp_r[i-1];
      neg_r[i+1] <= neg_r[i];
    end
  end

  // final multiply by x
  always_ff @(posedge clk) begin
    fin_r            <= 32'(rnd(64'(acc_r[NSTEP]) * 64'(xp_r[NSTEP]), 30));
    neg_r[NSTEP+2]   <= neg_r[NSTEP+1];
  end

  // round to coefficient width, clamp, apply sign
  always_comb begin
    fin_round = (FRAC == 30) ? 64'(fin_r) : rnd(64'(fin_r), 30 - FRAC);
    if (fin_round < 0) fin_round = 0;
    if (fin_round > (64'sd1 <<< FRAC)) fin_round = 64'sd1 <<< FRAC;
    if (neg_r[NSTEP+2]) fin_round = -fin_round;
  end
  always_ff @(posedge clk) begin
    sine_r <= COEF_BITS'(fin_round);
  end
  assign sine = sine_r;
endmodule

// File: rtl/ear_matrix.sv
// ---------------------------------------------------------------------------
// ear_matrix
// Merge pipeline: multiplies the six sines and cosines into the nine entries.
// ---------------------------------------------------------------------------
module ear_matrix #(
  parameter int COEF_BITS = 16
) (
  input  logic                        clk,
  input  logic signed [COEF_BITS-1:0] sp, cp, sy, cy, sr, cr,
  output ear_pkg::out_item_t          mat
);
  localparam int FRAC = COEF_BITS - 2;
  localparam int PW   = 2 * COEF_BITS + 2;

  function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] v, input int sh);
    return (v + (PW'(1) <<< (sh - 1))) >>> sh;
  endfunction

  // entry in fb fraction bits to saturated Q1.15
  function automatic logic signed [15:0] q15(input logic signed [PW-1:0] v, input int fb);
    logic signed [PW+15:0] r;
    if (fb > 15) r = (PW+16)'(rnd(v, fb - 15));
    else         r = (PW+16)'(v) <<< (15 - fb);
    if (r > 32767)  r = 32767;
    if (r < -32768) r = -32768;
    return 16'(r);
  endfunction

  logic signed [PW-1:0] cpcy_r, cpsy_r, srcp_r, crcp_r, crsy_r, srcy_r, srsy_r, crcy_r;
  logic signed [COEF_BITS-1:0] sp_r, sp2_r;
  logic signed [PW-1:0] crcyf_r, crsyf_r, srcyf_r, srsyf_r;
  logic signed [PW-1:0] cpcy2_r, cpsy2_r, srcp2_r, crcp2_r, crsy2_r, srcy2_r, srsy2_r, crcy2_r;
  logic signed [PW-1:0] t01_r, t11_r, t02_r, t12_r;
  logic signed [PW-1:0] cpcy3_r, cpsy3_r, srcp3_r, crcp3_r, crsy3_r, srcy3_r, srsy3_r, crcy3_r;
  logic signed [COEF_BITS-1:0] sp3_r;
  ear_pkg::out_item_t mat_r;

  // two-factor products
  always_ff @(posedge clk) begin
    cpcy_r <= PW'(cp) * PW'(cy); cpsy_r <= PW'(cp) * PW'(sy);
    srcp_r <= PW'(sr) * PW'(cp); crcp_r <= PW'(cr) * PW'(cp);
    crsy_r <= PW'(cr) * PW'(sy); srcy_r <= PW'(sr) * PW'(cy);
    srsy_r <= PW'(sr) * PW'(sy); crcy_r <= PW'(cr) * PW'(cy);
    sp_r   <= sp;
  end

  // round inner products to F bits
  always_ff @(posedge clk) begin
    crcyf_r <= rnd(crcy_r, FRAC); crsyf_r <= rnd(crsy_r, FRAC);
    srcyf_r <= rnd(srcy_r, FRAC); srsyf_r <= rnd(srsy_r, FRAC);
    cpcy2_r <= cpcy_r; cpsy2_r <= cpsy_r; srcp2_r <= srcp_r; crcp2_r <= crcp_r;
    crsy2_r <= crsy_r; srcy2_r <= srcy_r; srsy2_r <= srsy_r; crcy2_r <= crcy_r;
    sp2_r   <= sp_r;
  end

  // three-factor products
  always_ff @(posedge clk) begin
    t01_r <= PW'(srcyf_r * PW'(sp2_r)); t11_r <= PW'(srsyf_r * PW'(sp2_r));
    t02_r <= PW'(crcyf_r * PW'(sp2_r)); t12_r <= PW'(crsyf_r * PW'(sp2_r));
    cpcy3_r <= cpcy2_r; cpsy3_r <= cpsy2_r; srcp3_r <= srcp2_r; crcp3_r <= crcp2_r;
    crsy3_r <= crsy2_r; srcy3_r <= srcy2_r; srsy3_r <= srsy2_r; crcy3_r <= crcy2_r;
    sp3_r   <= sp2_r;
  end

  // sums, rounding and saturation
  always_ff @(posedge clk) begin
    mat_r.m00 <= q15(cpcy3_r, 2 * FRAC);
    mat_r.m10 <= q15(cpsy3_r, 2 * FRAC);
    mat_r.m20 <= q15(-PW'(sp3_r), FRAC);
    mat_r.m01 <= q15(t01_r - crsy3_r, 2 * FRAC);
    mat_r.m11 <= q15(t11_r + crcy3_r, 2 * FRAC);
    mat_r.m21 <= q15(srcp3_r, 2 * FRAC);
    mat_r.m02 <= q15(t02_r + srsy3_r, 2 * FRAC);
    mat_r.m12 <= q15(t12_r - srcy3_r, 2 * FRAC);
    mat_r.m22 <= q15(crcp3_r, 2 * FRAC);
  end
  assign mat = mat_r;
endmodule

// File: rtl/ear_checker.sv
// ---------------------------------------------------------------------------
// ear_checker
// Port-level checks on the item flow of the rotation matrix block.
// ---------------------------------------------------------------------------
`include "euler_angles_to_rotation_matrix_top_assert.svh"
module ear_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);
  `EAR_ASSERT_IMP(a_never_busy, 1'b1, !busy)
  `EAR_ASSERT_DLY(a_latency, start && !busy, 13, out_valid)
  `EAR_ASSERT_IMP(a_no_phantom, out_valid, $past(start && !busy, 13))
endmodule

bind euler_angles_to_rotation_matrix_top ear_checker u_ear_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid));

// File: verif/euler_angles_to_rotation_matrix_top_tb.sv
// ---------------------------------------------------------------------------
// euler_angles_to_rotation_matrix_top_tb
// Drives binary angle triples into the rotation matrix block and compares
// every matrix it returns with a bit-exact fixed-point model kept here.
// ---------------------------------------------------------------------------
module euler_angles_to_rotation_matrix_top_tb;
  localparam int FRAC = 14;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  ear_pkg::in_item_t  in_item = '0;
  logic               out_valid;
  ear_pkg::out_item_t out_item;

  ear_pkg::out_item_t matrix_q[$];
  int        n_errors = 0;
  bit        no_idle = 1'b0;

  euler_angles_to_rotation_matrix_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  always #2 clk = ~clk;

  // round half up by sh bits (floor of v + half, arithmetic shift)
  function automatic longint rnd(longint v, int sh);
    if (sh == 0) return v;
    return (v + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  // sine of a 16-bit phase, F fraction bits
  function automatic longint sine_of(logic [15:0] p);
    longint x, x2, acc;
    logic [1:0] quad;
    quad = p[15:14];
    x = longint'(p[13:0]) <<< 16;
    if (quad[0]) x = (64'sd1 <<< 30) - x;
    x2 = rnd(x * x, 30);
    acc = ear_pkg::COEF[0];
    for (int i = 1; i < ear_pkg::NCOEF; i++)
      acc = longint'(ear_pkg::COEF[i]) + rnd(acc * x2, 30);
    acc = rnd(acc * x, 30);
    acc = rnd(acc, 30 - FRAC);
    if (acc < 0) acc = 0;
    if (acc > (64'sd1 <<< FRAC)) acc = 64'sd1 <<< FRAC;
    return quad[1] ? -acc : acc;
  endfunction

  function automatic logic [15:0] sat_q15(longint v, int fb);
    longint r;
    r = rnd(v, fb - 15);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic ear_pkg::out_item_t rotation_of(ear_pkg::in_item_t a);
    longint sp, cp, sy, cy, sr, cr, crcy, crsy, srcy, srsy;
    ear_pkg::out_item_t m;
    int fb2;
    fb2 = 2 * FRAC;
    sp = sine_of(a.pitch_angle); cp = sine_of(a.pitch_angle + 16'h4000);
    sy = sine_of(a.yaw_angle);   cy = sine_of(a.yaw_angle + 16'h4000);
    sr = sine_of(a.roll_angle);  cr = sine_of(a.roll_angle + 16'h4000);
    crcy = rnd(cr * cy, FRAC); crsy = rnd(cr * sy, FRAC);
    srcy = rnd(sr * cy, FRAC); srsy = rnd(sr * sy, FRAC);
    m.m00 = sat_q15(cp * cy, fb2);
    m.m10 = sat_q15(cp * sy, fb2);
    m.m20 = sat_q15(-sp <<< 1, 15);
    m.m01 = sat_q15(sp * srcy - cr * sy, fb2);
    m.m11 = sat_q15(sp * srsy + cr * cy, fb2);
    m.m21 = sat_q15(sr * cp, fb2);
    m.m02 = sat_q15(sp * crcy + sr * sy, fb2);
    m.m12 = sat_q15(sp * crsy - sr * cy, fb2);
    m.m22 = sat_q15(cr * cp, fb2);
    return m;
  endfunction

  // present one item, hold start until taken, then maybe idle
  task automatic send_angles(logic [15:0] p, logic [15:0] y, logic [15:0] r);
    ear_pkg::in_item_t a;
    a.pitch_angle = p; a.yaw_angle = y; a.roll_angle = r;
    start <= 1'b1;
    in_item <= a;
    do @(posedge clk); while (busy);
    matrix_q.push_back(rotation_of(a));
    if (!no_idle && $urandom_range(99) < 30) begin
      start <= 1'b0;
      in_item <= ear_pkg::in_item_t'(48'({$urandom, $urandom}));
      @(posedge clk);
    end
  endtask

  // compare each matrix against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (matrix_q.size() == 0) begin
        $display("%0t: unexpected matrix %h", $time, out_item);
        n_errors++;
      end else begin
        ear_pkg::out_item_t e;
        e = matrix_q.pop_front();
        if (e !== out_item) begin
          $display("%0t: mismatch expected %h actual %h", $time, e, out_item);
          n_errors++;
        end
      end
    end
  end

  task automatic test_directed();
    logic [15:0] edges[8] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                             16'h7FFF, 16'h8001, 16'hFFFF, 16'h0001};
    for (int i = 0; i < 8; i++) send_angles(edges[i], edges[(i + 3) % 8], edges[(i + 5) % 8]);
    send_angles(16'h2000, 16'h2000, 16'h2000);
    send_angles(16'hE000, 16'h6000, 16'hA000);
    send_angles(16'h4000, 16'h0000, 16'h0000);
    send_angles(16'h5555, 16'hAAAA, 16'h3FFF);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      no_idle = (i >= 300 && i < 500);
      if ($urandom_range(9) == 0)
        send_angles(16'({$urandom_range(3), 14'h0} + $urandom_range(3) - 1),
                    16'($urandom), 16'($urandom));
      else
        send_angles(16'($urandom), 16'($urandom), 16'($urandom));
    end
    no_idle = 1'b0;
    start <= 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(1040);
    while (matrix_q.size() != 0) @(posedge clk);
    repeat (ear_pkg::MAT_LAT + ear_pkg::SIN_LAT + 10) @(posedge clk);
    if (n_errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #200000;
    $display("TEST FAILED");
    $finish;
  end
endmodule

// File: filelist.f
+incdir+rtl
rtl/ear_pkg.sv
rtl/ear_sine_lane.sv
rtl/ear_matrix.sv
rtl/euler_angles_to_rotation_matrix_top.sv
rtl/ear_checker.sv
verif/euler_angles_to_rotation_matrix_top_tb.sv
